// ===== design/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

    localparam int KEY_W  = 64;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 4;
    localparam int CFG_W  = 5;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic wr_entry;     // store the input key at the input slot
        logic load;         // open a search over the entries in use
        logic step;         // compare the probed entry; record a hit or narrow the window
        logic finish;       // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic open;         // search window not empty
        logic hit;          // probed entry equals the target
        logic out_free;     // output register can take a result this cycle
    } t_dp_status;

endpackage

// ===== design/stbs_if.sv =====
// Valid/ready channel interfaces for search requests and search results.
interface stbs_in_if;
    import stbs_pkg::*;
    logic               valid;
    logic               ready;
    logic               command;
    logic [SLOT_W-1:0]  entry_slot;
    logic [KEY_W-1:0]   key;

    modport source (output valid, output command, output entry_slot, output key,
                    input ready);
    modport sink   (input valid, input command, input entry_slot, input key,
                    output ready);
endinterface

interface stbs_out_if;
    import stbs_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [POS_W-1:0]   position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

// ===== design/sorted_table_binary_search.sv =====
// Sorted key table with a sequential binary search, top level.
//
// Input channel i_req (valid/ready): command 0 stores key at entry_slot,
// command 1 searches for key. Writes give no result. Each search gives one
// item on o_rsp: found, and the matching position (0 when not found).
// i_cfg_we / i_cfg_data load entries_in_use, the number of sorted entries a
// search covers (values above the table depth act as the full table).
// Each probe is a registered read of the key memory (state S_READ) followed
// by a compare (state S_CMP); that memory read sets the pace. A search makes
// P probes, P at most floor(log2(N)) + 1 for N entries in use; a search that
// misses passes through S_READ once more to see the window empty. A write is
// stored at its accept. i_req.ready is high only while idle, so no new item is
// taken until a search has moved its result into the output register.
// A finished result waits in the output register; while the receiver stalls
// and a second search finishes, that search holds until the register frees.
// Reset clears the entry count and the output valid; table contents are
// unknown until written.
module sorted_table_binary_search #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [stbs_pkg::CFG_W-1:0]  i_cfg_data,
    stbs_in_if.sink                     i_req,
    stbs_out_if.source                  o_rsp
);
    import stbs_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    stbs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .i_in_command (i_req.command),
        .o_in_ready   (i_req.ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    stbs_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_entry_slot (i_req.entry_slot),
        .i_key        (i_req.key),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_found      (o_rsp.found),
        .o_position   (o_rsp.position)
    );

endmodule

// ===== design/stbs_ctrl.sv =====
// Search sequencer: accepts items, paces probes and hands off results.
module stbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_command,
    output logic                o_in_ready,
    input  stbs_pkg::t_dp_status i_status,
    output stbs_pkg::t_dp_cmd   o_cmd
);
    import stbs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_command == CMD_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        o_cmd.wr_entry = 1'b1;
                    end
                end
            end
            S_READ: begin
                // the probe address is presented this cycle; data lands next
                n_state = i_status.open ? S_CMP : S_DONE;
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.hit ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/stbs_dp.sv =====
// Key memory, search window registers, comparator and result register.
module stbs_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [stbs_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [stbs_pkg::SLOT_W-1:0] i_entry_slot,
    input  logic [stbs_pkg::KEY_W-1:0]  i_key,
    input  stbs_pkg::t_dp_cmd           i_cmd,
    output stbs_pkg::t_dp_status        o_status,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_found,
    output logic [stbs_pkg::POS_W-1:0]  o_position
);
    import stbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [KEY_BITS-1:0] r_mem [TABLE_ENTRIES];
    logic [KEY_BITS-1:0] r_rdata;
    logic [KEY_BITS-1:0] r_target;
    logic [CFG_W-1:0]    r_entries_in_use;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hx;          // one past the last entry still in play
    logic                r_hit;
    logic [POS_W-1:0]    r_hit_pos;
    logic                r_out_valid;
    logic                r_found;
    logic [POS_W-1:0]    r_position;

    logic [31:0]         w_count32;
    logic [CNT_W-1:0]    w_count;
    logic [CNT_W:0]      w_sum;
    logic [CNT_W-1:0]    w_mid;
    logic [IDX_W-1:0]    w_addr;
    logic                w_slot_ok;
    logic                w_eq;
    logic                w_less;

    // saturate the entry count to the table depth
    assign w_count32 = (32'(r_entries_in_use) > 32'(TABLE_ENTRIES)) ?
                       32'(TABLE_ENTRIES) : 32'(r_entries_in_use);
    assign w_count   = CNT_W'(w_count32);

    // midpoint of lo .. hx-1, rounded down
    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hx} - (CNT_W+1)'(1);
    assign w_mid  = w_sum[CNT_W:1];
    assign w_addr = IDX_W'(w_mid);

    assign w_slot_ok = 32'(i_entry_slot) < 32'(TABLE_ENTRIES);
    assign w_eq      = (r_rdata == r_target);
    assign w_less    = (r_target < r_rdata);

    assign o_status.open     = (r_lo < r_hx);
    assign o_status.hit      = w_eq;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && w_slot_ok) begin
            r_mem[IDX_W'(i_entry_slot)] <= KEY_BITS'(i_key);
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target  <= KEY_BITS'(i_key);
            r_lo      <= '0;
            r_hx      <= w_count;
            r_hit     <= 1'b0;
            r_hit_pos <= '0;
        end else if (i_cmd.step) begin
            if (w_eq) begin
                r_hit     <= 1'b1;
                r_hit_pos <= POS_W'(w_mid);
            end else if (w_less) begin
                r_hx <= w_mid;
            end else begin
                r_lo <= w_mid + CNT_W'(1);
            end
        end
        if (i_cmd.finish) begin
            r_found    <= r_hit;
            r_position <= r_hit_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entries_in_use <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

    a_finish_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result pushed into a full output register");

    a_step_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_lo < r_hx))
        else $error("probe compared with an empty window");

    a_window_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !w_eq) |=> ((r_hx - r_lo) < $past(r_hx - r_lo)))
        else $error("search window did not narrow");

endmodule
